// File: rtl/er3d_pkg.sv
package er3d_pkg;

    // Coordinate field width and the internal width of rotated coordinates.
    // A rotation keeps the vector norm, so three turns stay below 2^(COORD_WIDTH).
    localparam int COORD_WIDTH = 24;
    localparam int IW          = COORD_WIDTH + 2;

    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // CORDIC: 32-bit turn, Q30 results, 30 iterations
    localparam int TURN_W       = 32;
    localparam int FRAC_BITS    = 30;
    localparam int CORDIC_STEPS = 30;
    localparam int COEF_MAG_W   = FRAC_BITS + 1;
    localparam int PROD_W       = IW + COEF_MAG_W;

    localparam logic signed [TURN_W-1:0] INV_GAIN = 32'sd652032874;

    // arctan(2^-i) in units of 2^-32 turn
    localparam logic signed [TURN_W-1:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81,
        32'sd41,        32'sd20,        32'sd10,        32'sd5,
        32'sd3,         32'sd1
    };

    // coefficient chain depth plus round-robin slack
    localparam int SETTLE_CYCLES = CORDIC_STEPS + 4;
    localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

    typedef enum logic [1:0] {
        REG_ANGLE_X = 2'd0,
        REG_ANGLE_Y = 2'd1,
        REG_ANGLE_Z = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_in;
        logic signed [COORD_WIDTH-1:0] y_in;
        logic signed [COORD_WIDTH-1:0] z_in;
        logic                          last_point;
    } point_in_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_out;
        logic signed [COORD_WIDTH-1:0] y_out;
        logic signed [COORD_WIDTH-1:0] z_out;
        logic                          last_out;
        logic                          clipped;
    } point_out_t;

    // cos/sin as magnitude and sign
    typedef struct packed {
        logic [COEF_MAG_W-1:0] cmag;
        logic [COEF_MAG_W-1:0] smag;
        logic                  cneg;
        logic                  sneg;
    } coef_t;

    // one CORDIC iteration's state
    typedef struct packed {
        logic signed [TURN_W-1:0] cx;
        logic signed [TURN_W-1:0] cy;
        logic signed [TURN_W-1:0] z;
        quad_t                    quad;
        cfg_idx_t                 tag;
    } cord_t;

    // plane pair (a, b) plus the coordinate that passes through
    typedef struct packed {
        logic signed [IW-1:0] a;
        logic signed [IW-1:0] b;
        logic signed [IW-1:0] p;
        logic                 last;
    } rot_t;

endpackage

// File: rtl/er3d_cordic_cell.sv
module er3d_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  er3d_pkg::cord_t   din,
    output er3d_pkg::cord_t   dout
);

    logic signed [er3d_pkg::TURN_W-1:0] cx;
    logic signed [er3d_pkg::TURN_W-1:0] cy;
    logic signed [er3d_pkg::TURN_W-1:0] dx;
    logic signed [er3d_pkg::TURN_W-1:0] dy;
    er3d_pkg::cord_t                    cell_next;
    er3d_pkg::cord_t                    cell_reg;

    always_comb
    begin
        cx = din.cx;
        cy = din.cy;
        dx = cy >>> STEP;
        dy = cx >>> STEP;
        cell_next      = din;
        if (din.z[er3d_pkg::TURN_W-1])
        begin
            cell_next.cx = cx + dx;
            cell_next.cy = cy - dy;
            cell_next.z  = din.z + er3d_pkg::ATAN_TURN[STEP];
        end
        else
        begin
            cell_next.cx = cx - dx;
            cell_next.cy = cy + dy;
            cell_next.z  = din.z - er3d_pkg::ATAN_TURN[STEP];
        end
    end

    // whole cell state in one register; tag resets to the first angle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

// File: rtl/er3d_coef_unit.sv
module er3d_coef_unit #(
    parameter int ANGLE_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [ANGLE_WIDTH-1:0] angle_x,
    input  logic [ANGLE_WIDTH-1:0] angle_y,
    input  logic [ANGLE_WIDTH-1:0] angle_z,
    output er3d_pkg::coef_t        coef_x,
    output er3d_pkg::coef_t        coef_y,
    output er3d_pkg::coef_t        coef_z
);

    er3d_pkg::cfg_idx_t              sel_reg;
    er3d_pkg::cfg_idx_t              sel_next;
    logic [ANGLE_WIDTH-1:0]          angle_sel;
    logic [er3d_pkg::TURN_W-1:0]     turn;
    er3d_pkg::cord_t                 chain [er3d_pkg::CORDIC_STEPS+1];
    er3d_pkg::cord_t                 tail;
    logic signed [er3d_pkg::TURN_W-1:0] cval;
    logic signed [er3d_pkg::TURN_W-1:0] sval;
    logic [er3d_pkg::TURN_W-1:0]     cabs;
    logic [er3d_pkg::TURN_W-1:0]     sabs;
    er3d_pkg::coef_t                 coef_new;
    er3d_pkg::coef_t                 coef_x_reg;
    er3d_pkg::coef_t                 coef_y_reg;
    er3d_pkg::coef_t                 coef_z_reg;

    // round-robin over the three angles, one injection per cycle
    always_comb
    begin
        unique case (sel_reg)
            er3d_pkg::REG_ANGLE_X: sel_next = er3d_pkg::REG_ANGLE_Y;
            er3d_pkg::REG_ANGLE_Y: sel_next = er3d_pkg::REG_ANGLE_Z;
            default:               sel_next = er3d_pkg::REG_ANGLE_X;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= er3d_pkg::REG_ANGLE_X;
        end
        else
        begin
            sel_reg <= sel_next;
        end
    end

    always_comb
    begin
        unique case (sel_reg)
            er3d_pkg::REG_ANGLE_X: angle_sel = angle_x;
            er3d_pkg::REG_ANGLE_Y: angle_sel = angle_y;
            default:               angle_sel = angle_z;
        endcase
        turn = er3d_pkg::TURN_W'(angle_sel) << (er3d_pkg::TURN_W - ANGLE_WIDTH);
        chain[0].cx   = er3d_pkg::INV_GAIN;
        chain[0].cy   = '0;
        chain[0].z    = {2'b00, turn[er3d_pkg::FRAC_BITS-1:0]};
        chain[0].quad = er3d_pkg::quad_t'(turn[er3d_pkg::TURN_W-1 -: 2]);
        chain[0].tag  = sel_reg;
    end

    for (genvar i = 0; i < er3d_pkg::CORDIC_STEPS; i++)
    begin : g_cell
        er3d_cordic_cell #(
            .STEP (i)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .din   (chain[i]),
            .dout  (chain[i+1])
        );
    end

    assign tail = chain[er3d_pkg::CORDIC_STEPS];

    // quadrant fold, then split into magnitude and sign
    always_comb
    begin
        unique case (tail.quad)
            er3d_pkg::QUAD_0:
            begin
                cval = tail.cx;
                sval = tail.cy;
            end
            er3d_pkg::QUAD_1:
            begin
                cval = -tail.cy;
                sval = tail.cx;
            end
            er3d_pkg::QUAD_2:
            begin
                cval = -tail.cx;
                sval = -tail.cy;
            end
            default:
            begin
                cval = tail.cy;
                sval = -tail.cx;
            end
        endcase
        cabs          = cval[er3d_pkg::TURN_W-1] ? er3d_pkg::TURN_W'(-cval)
                                                 : er3d_pkg::TURN_W'(cval);
        sabs          = sval[er3d_pkg::TURN_W-1] ? er3d_pkg::TURN_W'(-sval)
                                                 : er3d_pkg::TURN_W'(sval);
        coef_new.cmag = cabs[er3d_pkg::COEF_MAG_W-1:0];
        coef_new.smag = sabs[er3d_pkg::COEF_MAG_W-1:0];
        coef_new.cneg = cval[er3d_pkg::TURN_W-1];
        coef_new.sneg = sval[er3d_pkg::TURN_W-1];
    end

    always_ff @(posedge clk)
    begin
        unique case (tail.tag)
            er3d_pkg::REG_ANGLE_X: coef_x_reg <= coef_new;
            er3d_pkg::REG_ANGLE_Y: coef_y_reg <= coef_new;
            er3d_pkg::REG_ANGLE_Z: coef_z_reg <= coef_new;
            default: ;
        endcase
    end

    assign coef_x = coef_x_reg;
    assign coef_y = coef_y_reg;
    assign coef_z = coef_z_reg;

endmodule

// File: rtl/er3d_rot_cell.sv
module er3d_rot_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  er3d_pkg::rot_t  in_data,
    input  er3d_pkg::coef_t coef,
    output logic            out_valid,
    input  logic            out_ready,
    output er3d_pkg::rot_t  out_data
);

    localparam int IW = er3d_pkg::IW;
    localparam int PW = er3d_pkg::PROD_W;
    localparam int FB = er3d_pkg::FRAC_BITS;
    localparam logic [PW:0] HALF = (PW+1)'(1) << (FB - 1);

    // round(prod / 2^30), halves away from zero, then apply sign
    function automatic logic signed [IW+1:0] round_q30(input logic [PW-1:0] prod,
                                                      input logic          neg);
        logic [PW:0]   sum;
        logic [IW:0]   mag;
        logic signed [IW+1:0] sval;
        sum  = (PW+1)'(prod) + HALF;
        mag  = sum[FB +: IW+1];
        sval = $signed({1'b0, mag});
        return neg ? -sval : sval;
    endfunction

    // stage enables: a stage moves when empty or when its successor moves
    logic en1, en2, en3, en4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // stage 1: magnitudes
    logic [IW-1:0]        amag1_reg, bmag1_reg;
    logic                 aneg1_reg, bneg1_reg;
    logic signed [IW-1:0] p1_reg;
    logic                 last1_reg;
    logic [IW-1:0]        amag_next, bmag_next;

    // stage 2: products
    logic [PW-1:0]        pac2_reg, pbs2_reg, pas2_reg, pbc2_reg;
    logic                 nac2_reg, nbs2_reg, nas2_reg, nbc2_reg;
    logic signed [IW-1:0] p2_reg;
    logic                 last2_reg;

    // stage 3: rounded signed products
    logic signed [IW+1:0] rac3_reg, rbs3_reg, ras3_reg, rbc3_reg;
    logic signed [IW-1:0] p3_reg;
    logic                 last3_reg;

    // stage 4: rotated pair
    logic signed [IW+2:0] na_next, nb_next;
    er3d_pkg::rot_t       out4_reg;

    assign en4      = !v4_reg || out_ready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    always_comb
    begin
        amag_next = in_data.a[IW-1] ? IW'(-in_data.a) : IW'(in_data.a);
        bmag_next = in_data.b[IW-1] ? IW'(-in_data.b) : IW'(in_data.b);
        na_next   = (IW+3)'(rac3_reg) - (IW+3)'(rbs3_reg);
        nb_next   = (IW+3)'(ras3_reg) + (IW+3)'(rbc3_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            amag1_reg <= amag_next;
            bmag1_reg <= bmag_next;
            aneg1_reg <= in_data.a[IW-1];
            bneg1_reg <= in_data.b[IW-1];
            p1_reg    <= in_data.p;
            last1_reg <= in_data.last;
        end
        if (en2)
        begin
            pac2_reg  <= PW'(amag1_reg) * PW'(coef.cmag);
            pbs2_reg  <= PW'(bmag1_reg) * PW'(coef.smag);
            pas2_reg  <= PW'(amag1_reg) * PW'(coef.smag);
            pbc2_reg  <= PW'(bmag1_reg) * PW'(coef.cmag);
            nac2_reg  <= aneg1_reg ^ coef.cneg;
            nbs2_reg  <= bneg1_reg ^ coef.sneg;
            nas2_reg  <= aneg1_reg ^ coef.sneg;
            nbc2_reg  <= bneg1_reg ^ coef.cneg;
            p2_reg    <= p1_reg;
            last2_reg <= last1_reg;
        end
        if (en3)
        begin
            rac3_reg  <= round_q30(pac2_reg, nac2_reg);
            rbs3_reg  <= round_q30(pbs2_reg, nbs2_reg);
            ras3_reg  <= round_q30(pas2_reg, nas2_reg);
            rbc3_reg  <= round_q30(pbc2_reg, nbc2_reg);
            p3_reg    <= p2_reg;
            last3_reg <= last2_reg;
        end
        if (en4)
        begin
            // norm is preserved, so the pair fits IW bits
            out4_reg.a    <= na_next[IW-1:0];
            out4_reg.b    <= nb_next[IW-1:0];
            out4_reg.p    <= p3_reg;
            out4_reg.last <= last3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = out4_reg;

endmodule

// File: rtl/euler_rotate_3d_points.sv
// 13 register stages: three 4-stage rotation cells plus the saturating output register.
// Throughput: one point per cycle, back to back, when no coefficient refresh is under way;
//   stages collapse bubbles under back-pressure.
// Reset: angles clear to 0; pt_ready stays low after reset and after every angle write until
//   the settle timer ends, while the 30-cell CORDIC chain refreshes the cos/sin coefficients.
module euler_rotate_3d_points #(
    parameter int ANGLE_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,

    // point stream in
    input  logic                   pt_valid,
    output logic                   pt_ready,
    input  er3d_pkg::point_in_t    pt_data,

    // rotated point stream out
    output logic                   res_valid,
    input  logic                   res_ready,
    output er3d_pkg::point_out_t   res_data,

    // angle registers
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [ANGLE_WIDTH-1:0] cfg_wdata
);

    localparam int IW = er3d_pkg::IW;
    localparam int CW = er3d_pkg::COORD_WIDTH;

    // ------------------------------------------------------------------
    // Angle registers and coefficient settle timer.
    // Any accepted write restarts the timer; points are held off until
    // the chain has delivered fresh coefficients for all three angles.
    // ------------------------------------------------------------------
    logic [ANGLE_WIDTH-1:0]      angle_x_reg, angle_y_reg, angle_z_reg;
    logic [er3d_pkg::SETTLE_W-1:0] settle_reg;
    logic                        cfg_hit;
    logic                        busy;

    assign cfg_hit = cfg_we && (cfg_index == er3d_pkg::REG_ANGLE_X ||
                                cfg_index == er3d_pkg::REG_ANGLE_Y ||
                                cfg_index == er3d_pkg::REG_ANGLE_Z);
    assign busy    = (settle_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_x_reg <= '0;
            angle_y_reg <= '0;
            angle_z_reg <= '0;
            settle_reg  <= er3d_pkg::SETTLE_W'(er3d_pkg::SETTLE_CYCLES);
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    er3d_pkg::REG_ANGLE_X: angle_x_reg <= cfg_wdata;
                    er3d_pkg::REG_ANGLE_Y: angle_y_reg <= cfg_wdata;
                    er3d_pkg::REG_ANGLE_Z: angle_z_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cfg_hit)
            begin
                settle_reg <= er3d_pkg::SETTLE_W'(er3d_pkg::SETTLE_CYCLES);
            end
            else if (busy)
            begin
                settle_reg <= settle_reg - er3d_pkg::SETTLE_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Coefficient generator: pipelined CORDIC, angles fed round-robin.
    // ------------------------------------------------------------------
    er3d_pkg::coef_t coef_x, coef_y, coef_z;

    er3d_coef_unit #(
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_coef (
        .clk     (clk),
        .rst_n   (rst_n),
        .angle_x (angle_x_reg),
        .angle_y (angle_y_reg),
        .angle_z (angle_z_reg),
        .coef_x  (coef_x),
        .coef_y  (coef_y),
        .coef_z  (coef_z)
    );

    // ------------------------------------------------------------------
    // Rotation chain. Each cell turns its (a, b) pair and passes p along.
    //   cell 0: (x, y) by angle_z, p = z
    //   cell 1: (z, x) by angle_y, p = y
    //   cell 2: (y, z) by angle_x, p = x
    // ------------------------------------------------------------------
    logic           c0_in_valid, c0_in_ready;
    logic           c0_valid, c1_valid, c2_valid;
    logic           c1_ready, c2_ready, out_en;
    er3d_pkg::rot_t c0_in, c0_out, c1_in, c1_out, c2_in, c2_out;

    assign c0_in_valid = pt_valid && !busy;
    assign pt_ready    = c0_in_ready && !busy;

    always_comb
    begin
        c0_in.a    = IW'(pt_data.x_in);
        c0_in.b    = IW'(pt_data.y_in);
        c0_in.p    = IW'(pt_data.z_in);
        c0_in.last = pt_data.last_point;

        c1_in.a    = c0_out.p;
        c1_in.b    = c0_out.a;
        c1_in.p    = c0_out.b;
        c1_in.last = c0_out.last;

        c2_in.a    = c1_out.p;
        c2_in.b    = c1_out.a;
        c2_in.p    = c1_out.b;
        c2_in.last = c1_out.last;
    end

    er3d_rot_cell u_rot_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c0_in_valid),
        .in_ready  (c0_in_ready),
        .in_data   (c0_in),
        .coef      (coef_z),
        .out_valid (c0_valid),
        .out_ready (c1_ready),
        .out_data  (c0_out)
    );

    er3d_rot_cell u_rot_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c0_valid),
        .in_ready  (c1_ready),
        .in_data   (c1_in),
        .coef      (coef_y),
        .out_valid (c1_valid),
        .out_ready (c2_ready),
        .out_data  (c1_out)
    );

    er3d_rot_cell u_rot_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c1_valid),
        .in_ready  (c2_ready),
        .in_data   (c2_in),
        .coef      (coef_x),
        .out_valid (c2_valid),
        .out_ready (out_en),
        .out_data  (c2_out)
    );

    // ------------------------------------------------------------------
    // Output register: saturate to the field width, flag any clip.
    // Cell 2 leaves a = y, b = z, p = x.
    // ------------------------------------------------------------------
    logic                 res_valid_reg;
    er3d_pkg::point_out_t res_data_reg;
    er3d_pkg::point_out_t res_next;
    logic                 ovf_x, ovf_y, ovf_z;

    assign out_en = !res_valid_reg || res_ready;

    always_comb
    begin
        ovf_x = (c2_out.p[IW-1:CW-1] != {(IW-CW+1){c2_out.p[IW-1]}});
        ovf_y = (c2_out.a[IW-1:CW-1] != {(IW-CW+1){c2_out.a[IW-1]}});
        ovf_z = (c2_out.b[IW-1:CW-1] != {(IW-CW+1){c2_out.b[IW-1]}});

        res_next.x_out    = ovf_x ? (c2_out.p[IW-1] ? er3d_pkg::COORD_MIN : er3d_pkg::COORD_MAX)
                                  : c2_out.p[CW-1:0];
        res_next.y_out    = ovf_y ? (c2_out.a[IW-1] ? er3d_pkg::COORD_MIN : er3d_pkg::COORD_MAX)
                                  : c2_out.a[CW-1:0];
        res_next.z_out    = ovf_z ? (c2_out.b[IW-1] ? er3d_pkg::COORD_MIN : er3d_pkg::COORD_MAX)
                                  : c2_out.b[CW-1:0];
        res_next.last_out = c2_out.last;
        res_next.clipped  = ovf_x || ovf_y || ovf_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            res_valid_reg <= c2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            res_data_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // no point enters while coefficients are being refreshed
    a_hold_while_settling: assert property (
        @(posedge clk) disable iff (!rst_n)
        busy |-> !pt_ready
    ) else $error("point transfer offered during coefficient refresh");

    // an angle write closes the input on the next cycle
    a_write_closes_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        cfg_hit |=> (!pt_ready && busy)
    ) else $error("input open right after angle write");

    // a clipped result carries at least one coordinate at a limit
    a_clip_at_limit: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.clipped) |->
            (res_data.x_out == er3d_pkg::COORD_MAX || res_data.x_out == er3d_pkg::COORD_MIN ||
             res_data.y_out == er3d_pkg::COORD_MAX || res_data.y_out == er3d_pkg::COORD_MIN ||
             res_data.z_out == er3d_pkg::COORD_MAX || res_data.z_out == er3d_pkg::COORD_MIN)
    ) else $error("clipped flag without saturated coordinate");

endmodule
